FILE: hdl/htfd_pkg.sv
// Shared types and constants for the humidity/temperature frame decoder.
package htfd_pkg;

   // CRC-8 parameters of the sensor reply
   localparam logic [7:0] CRC_POLY = 8'h31;
   localparam logic [7:0] CRC_INIT = 8'hFF;

   // Conversion constants
   localparam int T_SCALE  = 17500;
   localparam int H_SCALE  = 12500;
   localparam int RAW_FULL = 65535;
   localparam int T_OFFSET = 4500;
   localparam int H_OFFSET = 600;
   localparam int H_MAX    = 10000;

   // Port and product widths
   localparam int BYTE_W    = 8;
   localparam int TEMP_W    = 15;
   localparam int HUM_W     = 14;
   localparam int STATUS_W  = 2;
   localparam int RSP_DATA_W = 32;
   localparam int T_PROD_W  = 31;
   localparam int H_PROD_W  = 30;

   // Result status codes
   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_T_BAD = 2'd1,
      STATUS_H_BAD = 2'd2
   } status_type;

   // Complete reply handed from the parser to the scaling pipeline
   typedef struct packed {
      logic       valid;
      logic [15:0] temperature_word;
      logic [15:0] humidity_word;
      status_type status;
   } frame_type;

endpackage

FILE: hdl/htfd_parser.sv
// Reply byte parser: byte position tracking, CRC-8 checks and raw word capture.
module htfd_parser import htfd_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              fire,
   input  logic [BYTE_W-1:0] rx_byte,
   input  logic              frame_start,
   output frame_type         frame
);

   typedef enum logic [6:0] {
      POS_IDLE  = 7'b0000001,
      POS_T_LO  = 7'b0000010,
      POS_T_CRC = 7'b0000100,
      POS_H_HI  = 7'b0001000,
      POS_H_LO  = 7'b0010000,
      POS_H_CRC = 7'b0100000,
      POS_T_HI  = 7'b1000000
   } pos_type;

   // one CRC-8 byte update, MSB first
   function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] c;
      c = crc ^ b;
      for (int k = 0; k < 8; k++) begin
         if (c[7]) begin
            c = {c[6:0], 1'b0} ^ CRC_POLY;
         end else begin
            c = {c[6:0], 1'b0};
         end
      end
      return c;
   endfunction

   pos_type     pos_ff, pos_in;
   logic [7:0]  crc_ff, crc_in;
   logic [15:0] t_word_ff, t_word_in;
   logic [15:0] h_word_ff, h_word_in;
   logic        t_bad_ff, t_bad_in;
   pos_type     pos_eff;

   // next-state logic for one accepted byte
   always_comb begin
      pos_in    = pos_ff;
      crc_in    = crc_ff;
      t_word_in = t_word_ff;
      h_word_in = h_word_ff;
      t_bad_in  = t_bad_ff;
      frame.valid            = 1'b0;
      frame.temperature_word = t_word_ff;
      frame.humidity_word    = h_word_ff;
      frame.status           = STATUS_OK;
      pos_eff = frame_start ? POS_T_HI : pos_ff;
      if (fire) begin
         unique case (pos_eff)
            POS_T_HI: begin
               crc_in    = crc8_step(CRC_INIT, rx_byte);
               t_word_in = {rx_byte, t_word_ff[7:0]};
               t_bad_in  = 1'b0;
               pos_in    = POS_T_LO;
            end
            POS_T_LO: begin
               crc_in    = crc8_step(crc_ff, rx_byte);
               t_word_in = {t_word_ff[15:8], rx_byte};
               pos_in    = POS_T_CRC;
            end
            POS_T_CRC: begin
               t_bad_in = (crc_ff != rx_byte);
               crc_in   = CRC_INIT;
               pos_in   = POS_H_HI;
            end
            POS_H_HI: begin
               crc_in    = crc8_step(CRC_INIT, rx_byte);
               h_word_in = {rx_byte, h_word_ff[7:0]};
               pos_in    = POS_H_LO;
            end
            POS_H_LO: begin
               crc_in    = crc8_step(crc_ff, rx_byte);
               h_word_in = {h_word_ff[15:8], rx_byte};
               pos_in    = POS_H_CRC;
            end
            POS_H_CRC: begin
               crc_in      = CRC_INIT;
               pos_in      = POS_IDLE;
               frame.valid = 1'b1;
               if (t_bad_ff) begin
                  frame.status = STATUS_T_BAD;
               end else if (crc_ff != rx_byte) begin
                  frame.status = STATUS_H_BAD;
               end
            end
            default: begin
               // stray byte without a start mark
               pos_in = POS_IDLE;
            end
         endcase
      end
   end

   // parser state
   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= POS_IDLE;
         crc_ff    <= CRC_INIT;
         t_word_ff <= '0;
         h_word_ff <= '0;
         t_bad_ff  <= 1'b0;
      end else begin
         pos_ff    <= pos_in;
         crc_ff    <= crc_in;
         t_word_ff <= t_word_in;
         h_word_ff <= h_word_in;
         t_bad_ff  <= t_bad_in;
      end
   end

endmodule

FILE: hdl/htfd_scale.sv
// Scaling pipeline: product stage, then divide by full scale, offset, clamp, result register.
module htfd_scale import htfd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  frame_type             frame,
   output logic                  up_ready,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   output logic [STATUS_W-1:0]   rsp_tuser
);

   logic                valid1_ff;
   status_type          status1_ff;
   logic [T_PROD_W-1:0] t_prod1_ff;
   logic [H_PROD_W-1:0] h_prod1_ff;

   logic                out_valid_ff;
   logic [TEMP_W-1:0]   temp_ff, temp_in;
   logic [HUM_W-1:0]    hum_ff, hum_in;
   status_type          status_ff;

   logic                out_move;

   // pipeline advances when the result register is free or being drained
   assign out_move = !out_valid_ff || rsp_tready;
   assign up_ready = !valid1_ff || out_move;

   // product stage
   always_ff @(posedge clock) begin
      if (reset) begin
         valid1_ff <= 1'b0;
      end else if (up_ready) begin
         valid1_ff <= frame.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (up_ready) begin
         status1_ff <= frame.status;
         t_prod1_ff <= {15'd0, frame.temperature_word} * T_PROD_W'(T_SCALE);
         h_prod1_ff <= {14'd0, frame.humidity_word} * H_PROD_W'(H_SCALE);
      end
   end

   // floor(p / 65535): q0 = p >> 16, remainder q0 + low half stays below twice the divisor
   logic [TEMP_W-1:0]  t_q0, t_q;
   logic [16:0]        t_rem;
   logic signed [15:0] t_val;
   logic [HUM_W-1:0]   h_q0, h_q;
   logic [16:0]        h_rem;

   always_comb begin
      t_q0  = t_prod1_ff[T_PROD_W-1:16];
      t_rem = {1'b0, t_prod1_ff[15:0]} + 17'(t_q0);
      t_q   = t_q0 + TEMP_W'(t_rem >= 17'(RAW_FULL));
      t_val = signed'({1'b0, t_q}) - 16'(T_OFFSET);

      h_q0  = h_prod1_ff[H_PROD_W-1:16];
      h_rem = {1'b0, h_prod1_ff[15:0]} + 17'(h_q0);
      h_q   = h_q0 + HUM_W'(h_rem >= 17'(RAW_FULL));

      temp_in = t_val[TEMP_W-1:0];
      if (h_q < HUM_W'(H_OFFSET)) begin
         hum_in = '0;
      end else if (h_q > HUM_W'(H_OFFSET + H_MAX)) begin
         hum_in = HUM_W'(H_MAX);
      end else begin
         hum_in = h_q - HUM_W'(H_OFFSET);
      end

      // values read zero on any CRC failure
      if (status1_ff != STATUS_OK) begin
         temp_in = '0;
         hum_in  = '0;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_move) begin
         out_valid_ff <= valid1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_move) begin
         temp_ff   <= temp_in;
         hum_ff    <= hum_in;
         status_ff <= status1_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'd0, hum_ff, temp_ff};
   assign rsp_tuser  = status_ff;

endmodule

FILE: hdl/humidity_temperature_frame_decoder.sv
// Top level of the humidity/temperature reply frame decoder.
// Takes one reply byte per cycle while req_tready is high (byte 0 marked by
// req_tuser) and, after the sixth byte of a reply, gives one result through the
// product and result registers: temperature and humidity in hundredths, zeroed
// with a nonzero status when a CRC-8 (poly 0x31, init 0xFF) fails. The parser
// handles each byte in the cycle it is accepted; the final byte feeds a multiply
// stage and a divide/offset/clamp stage ending in the result register. req_tready
// drops only while both pipeline registers hold items and rsp_tready is low.
module humidity_temperature_frame_decoder import htfd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [BYTE_W-1:0]     req_tdata,  // [7:0] rx_byte
   input  logic                  req_tuser,  // [0] frame_start
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [RSP_DATA_W-1:0] rsp_tdata,  // [14:0] temperature_centi, [28:15] humidity_centi, zero pad
   output logic [STATUS_W-1:0]   rsp_tuser   // [1:0] status
);

   logic      req_fire;
   frame_type frame;

   assign req_fire = req_tvalid && req_tready;

   htfd_parser u_parser (
      .clock       (clock),
      .reset       (reset),
      .fire        (req_fire),
      .rx_byte     (req_tdata),
      .frame_start (req_tuser),
      .frame       (frame)
   );

   htfd_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .frame      (frame),
      .up_ready   (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   // a failed check never carries values
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser != STATUS_OK) |-> (rsp_tdata == '0))
      else $error("nonzero values with CRC failure");

   // humidity stays clamped
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[28:15] <= 14'(H_MAX)))
      else $error("humidity above clamp");

   // status never holds the unused code
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tuser <= STATUS_H_BAD))
      else $error("invalid status code");

   // input only stalls behind a full output
   assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("input stalled with free output");

endmodule
